### hdl/emt_pkg.sv
// Shared types, constants and the range classifier for the extent map table.
// Depends on nothing; imported by the top level.
package emt_pkg;

   localparam int VIRT_W = 48;
   localparam int PHYS_W = 48;
   localparam int LEN_W  = 32;
   localparam int IDX_W  = 7;
   localparam int WIDE_W = 64;
   localparam int ENTRY_W = VIRT_W + PHYS_W + LEN_W;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      OV_LEFT_NONE  = 3'd0,
      OV_LEFT_ADJ   = 3'd1,
      OV_LEFT_PART  = 3'd2,
      OV_INSIDE     = 3'd3,
      OV_COVERS     = 3'd4,
      OV_RIGHT_PART = 3'd5,
      OV_RIGHT_ADJ  = 3'd6,
      OV_RIGHT_NONE = 3'd7
   } ov_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [PHYS_W-1:0] pstart;
      logic [VIRT_W-1:0] vstart;
   } entry_type;

   // Classifies range [a, ae) against range [b, be).
   function automatic ov_type classify(input logic [WIDE_W-1:0] a, input logic [WIDE_W-1:0] ae,
                                       input logic [WIDE_W-1:0] b, input logic [WIDE_W-1:0] be);
      ov_type r;
      if (a < b) begin
         if (ae < b) r = OV_LEFT_NONE;
         else if (ae == b) r = OV_LEFT_ADJ;
         else if (ae >= be) r = OV_COVERS;
         else r = OV_LEFT_PART;
      end else if (a > b) begin
         if (a > be) r = OV_RIGHT_NONE;
         else if (a == be) r = OV_RIGHT_ADJ;
         else if (ae > be) r = OV_RIGHT_PART;
         else r = OV_INSIDE;
      end else begin
         r = (ae > be) ? OV_COVERS : OV_INSIDE;
      end
      return r;
   endfunction

endpackage

### hdl/emt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module emt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### hdl/extent_map_table.sv
// Extent map table: add, remove, lookup and read over a table held in one RAM.
// Remove, lookup and add scan the entries in order, one RAM read per scanned entry. Each refill
// from the tail during an add, and the tail move of a remove, adds a tail read and write. Read
// fetches the indexed entry, and a zero length or a bad index is answered without a scan.
// One request is in flight at a time and a stalled response holds the sequencer. Reset clears
// the entry count and the control state; the RAM contents are left as they are.
module extent_map_table #(
   parameter int CAPACITY = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata: virtual_start[47:0], physical_start[95:48], sector_count[127:96],
   //        entry_index[134:128], zero fill[135]
   input  logic [135:0]  req_tdata,
   // tuser: operation[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata: out_virtual[47:0], out_physical[95:48], out_sectors[127:96],
   //        out_index[134:128], entry_count[141:135], zero fill[143:142]
   output logic [143:0]  rsp_tdata,
   // tuser: ok[0]
   output logic          rsp_tuser
);
   import emt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_EVAL, S_TAIL_RD, S_TAIL_WR, S_FINISH, S_RESP
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            has_slot_ff, has_slot_in;
   logic            done_ff, done_in;

   op_type            op_ff, op_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [IW-1:0]     slot_ff, slot_in;
   logic [VIRT_W-1:0] pv_ff, pv_in;
   logic [PHYS_W-1:0] pp_ff, pp_in;
   logic [WIDE_W-1:0] pn_ff, pn_in;
   logic              ok_ff, ok_in;
   logic [VIRT_W-1:0] ov_ff, ov_in;
   logic [PHYS_W-1:0] op_res_ff, op_res_in;
   logic [LEN_W-1:0]  os_ff, os_in;
   logic [IDX_W-1:0]  oi_ff, oi_in;
   logic [143:0]      rsp_data_ff, rsp_data_in;
   logic              rsp_ok_ff, rsp_ok_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   entry_type         wr_data, rd_data;

   logic [VIRT_W-1:0] in_v;
   logic [PHYS_W-1:0] in_p;
   logic [LEN_W-1:0]  in_n;
   logic [IDX_W-1:0]  in_idx;

   logic [WIDE_W-1:0] ev, ep, el, ee_v, ee_p, pe_v, pe_p;
   ov_type            vo, po;
   logic [WIDE_W-1:0] lk_d;
   logic              lk_hit;

   assign in_v   = req_tdata[47:0];
   assign in_p   = req_tdata[95:48];
   assign in_n   = req_tdata[127:96];
   assign in_idx = req_tdata[134:128];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

   emt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Range ends of the pending extent and of the entry just read, their overlap classes and the lookup hit.
   always_comb begin
      ev   = WIDE_W'(rd_data.vstart);
      ep   = WIDE_W'(rd_data.pstart);
      el   = WIDE_W'(rd_data.len);
      ee_v = ev + el;
      ee_p = ep + el;
      pe_v = WIDE_W'(pv_ff) + pn_ff;
      pe_p = WIDE_W'(pp_ff) + pn_ff;
      vo   = classify(WIDE_W'(pv_ff), pe_v, ev, ee_v);
      po   = classify(WIDE_W'(pp_ff), pe_p, ep, ee_p);
      lk_d = WIDE_W'(pv_ff) - ev;
      lk_hit = (WIDE_W'(pv_ff) >= ev) && (WIDE_W'(pv_ff) < ee_v);
   end

   // Sequencer next-state and datapath.
   always_comb begin
      logic take;
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      has_slot_in  = has_slot_ff;
      done_in      = done_ff;
      op_in        = op_ff;
      i_in         = i_ff;
      slot_in      = slot_ff;
      pv_in        = pv_ff;
      pp_in        = pp_ff;
      pn_in        = pn_ff;
      ok_in        = ok_ff;
      ov_in        = ov_ff;
      op_res_in    = op_res_ff;
      os_in        = os_ff;
      oi_in        = oi_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      wr_en        = 1'b0;
      wr_addr      = i_ff[IW-1:0];
      wr_data      = rd_data;
      rd_addr      = i_ff[IW-1:0];
      take         = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in       = op_type'(req_tuser);
               pv_in       = in_v;
               pp_in       = in_p;
               pn_in       = WIDE_W'(in_n);
               has_slot_in = 1'b0;
               done_in     = 1'b0;
               i_in        = '0;
               ok_in       = 1'b0;
               ov_in       = '0;
               op_res_in   = '0;
               os_in       = '0;
               oi_in       = '0;
               state_in    = S_FETCH;
               case (op_type'(req_tuser))
                  OP_ADD, OP_REMOVE: begin
                     if (in_n == '0) state_in = S_RESP;
                  end
                  OP_READ: begin
                     if (32'(in_idx) < 32'(count_ff)) i_in = CW'(in_idx);
                     else state_in = S_RESP;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Issue the read of slot i, or finish the scan.
         S_FETCH: begin
            if (i_ff < count_ff) begin
               state_in = S_EVAL;
            end else if (op_ff == OP_ADD) begin
               state_in = S_FINISH;
            end else begin
               if (op_ff == OP_LOOKUP) oi_in = IDX_W'(count_ff);
               state_in = S_RESP;
            end
         end

         S_EVAL: begin
            case (op_ff)
               OP_ADD: begin
                  if (vo == po) begin
                     case (vo)
                        OV_INSIDE: begin
                           done_in  = 1'b1;
                        end
                        OV_LEFT_ADJ: begin
                           pn_in = pn_ff + el;
                           take  = 1'b1;
                        end
                        OV_RIGHT_ADJ: begin
                           pv_in = rd_data.vstart;
                           pp_in = rd_data.pstart;
                           pn_in = pn_ff + el;
                           take  = 1'b1;
                        end
                        OV_COVERS: begin
                           take = 1'b1;
                        end
                        OV_LEFT_PART: begin
                           if ((ev - WIDE_W'(pv_ff)) == (ep - WIDE_W'(pp_ff))) begin
                              pn_in = el + (ev - WIDE_W'(pv_ff));
                              take  = 1'b1;
                           end
                        end
                        OV_RIGHT_PART: begin
                           if ((WIDE_W'(pv_ff) - ev) == (WIDE_W'(pp_ff) - ep)) begin
                              pn_in = pe_v - ev;
                              pv_in = rd_data.vstart;
                              pp_in = rd_data.pstart;
                              take  = 1'b1;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  // A contained hit ends the scan; otherwise merge, refill or move on.
                  if (vo == po && vo == OV_INSIDE) begin
                     state_in = S_FINISH;
                  end else if (!take) begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_FETCH;
                  end else if (!has_slot_ff) begin
                     has_slot_in = 1'b1;
                     slot_in     = i_ff[IW-1:0];
                     i_in        = i_ff + 1'b1;
                     state_in    = S_FETCH;
                  end else begin
                     state_in = S_TAIL_RD;
                  end
               end
               OP_REMOVE: begin
                  if (rd_data.vstart == pv_ff && el == pn_ff) begin
                     ok_in    = 1'b1;
                     state_in = S_TAIL_RD;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_FETCH;
                  end
               end
               OP_LOOKUP: begin
                  if (lk_hit) begin
                     ok_in     = 1'b1;
                     ov_in     = rd_data.vstart;
                     op_res_in = rd_data.pstart + lk_d[PHYS_W-1:0];
                     os_in     = rd_data.len - lk_d[LEN_W-1:0];
                     oi_in     = IDX_W'(i_ff + 1'b1);
                     state_in  = S_RESP;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_FETCH;
                  end
               end
               default: begin
                  ok_in     = 1'b1;
                  ov_in     = rd_data.vstart;
                  op_res_in = rd_data.pstart;
                  os_in     = rd_data.len;
                  state_in  = S_RESP;
               end
            endcase
         end

         // Read the tail entry so that it can fill slot i.
         S_TAIL_RD: begin
            rd_addr  = IW'(count_ff - 1'b1);
            state_in = S_TAIL_WR;
         end

         // Move the tail into slot i; an add re-examines the same slot.
         S_TAIL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[IW-1:0];
            wr_data  = rd_data;
            count_in = count_ff - 1'b1;
            state_in = (op_ff == OP_ADD) ? S_FETCH : S_RESP;
         end

         // Write back the merged extent, or append a new one if there is room; a contained extent writes nothing.
         S_FINISH: begin
            wr_data.vstart = pv_ff;
            wr_data.pstart = pp_ff;
            wr_data.len    = (pn_ff > WIDE_W'(LEN_MAX)) ? LEN_MAX : pn_ff[LEN_W-1:0];
            if (has_slot_ff) begin
               wr_en   = 1'b1;
               wr_addr = slot_ff;
               ok_in   = 1'b1;
            end else if (done_ff) begin
               ok_in = 1'b1;
            end else if (count_ff < CW'(CAPACITY)) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IW-1:0];
               count_in = count_ff + 1'b1;
               ok_in    = 1'b1;
            end
            state_in = S_RESP;
         end

         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_data_in  = {2'b00, IDX_W'(count_ff), oi_ff, os_ff, op_res_ff, ov_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         has_slot_ff  <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         has_slot_ff  <= has_slot_in;
         done_ff      <= done_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      i_ff        <= i_in;
      slot_ff     <= slot_in;
      pv_ff       <= pv_in;
      pp_ff       <= pp_in;
      pn_ff       <= pn_in;
      ok_ff       <= ok_in;
      ov_ff       <= ov_in;
      op_res_ff   <= op_res_in;
      os_ff       <= os_in;
      oi_ff       <= oi_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the extent map table: drives add, remove, lookup and read
// requests under random idling, and checks every response against a predictor of the table.
// Depends on emt_pkg and extent_map_table.
module tb_top;
   import emt_pkg::*;

   localparam int SLOTS = 64;
   localparam int RANDOM_REQUESTS = 460;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct {
      logic        ok;
      logic [47:0] virt;
      logic [47:0] phys;
      logic [31:0] secs;
      logic [6:0]  idx;
      logic [6:0]  cnt;
   } response_type;

   // Predictor of the table and store of the responses still owed.
   class extent_scoreboard;
      logic [47:0] tab_virt [SLOTS];
      logic [47:0] tab_phys [SLOTS];
      logic [31:0] tab_len [SLOTS];
      int unsigned count;
      response_type owed [$];
      int errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      function ov_type range_class(longint unsigned a, longint unsigned ae,
                                   longint unsigned b, longint unsigned be);
         if (a < b) begin
            if (ae < b) return OV_LEFT_NONE;
            if (ae == b) return OV_LEFT_ADJ;
            return (ae >= be) ? OV_COVERS : OV_LEFT_PART;
         end
         if (a > b) begin
            if (a > be) return OV_RIGHT_NONE;
            if (a == be) return OV_RIGHT_ADJ;
            return (ae > be) ? OV_RIGHT_PART : OV_INSIDE;
         end
         return (ae > be) ? OV_COVERS : OV_INSIDE;
      endfunction

      // Merges the new extent into the table, or appends it.
      function bit merge_extent(longint unsigned v, longint unsigned p, longint unsigned n);
         int unsigned i, slot;
         bit has_slot, covered, take;
         ov_type vc, pc;
         longint unsigned ev, ep, el;
         i = 0;
         slot = 0;
         has_slot = 0;
         covered = 0;
         if (n == 0) return 0;
         while (i < count) begin
            ev = tab_virt[i];
            ep = tab_phys[i];
            el = tab_len[i];
            vc = range_class(v, v + n, ev, ev + el);
            pc = range_class(p, p + n, ep, ep + el);
            take = 0;
            if (vc == pc) begin
               if (vc == OV_INSIDE) begin
                  covered = 1;
                  break;
               end
               case (vc)
                  OV_LEFT_ADJ: begin
                     n = n + el;
                     take = 1;
                  end
                  OV_RIGHT_ADJ: begin
                     v = ev;
                     p = ep;
                     n = n + el;
                     take = 1;
                  end
                  OV_COVERS: take = 1;
                  OV_LEFT_PART: begin
                     if (ev - v == ep - p) begin
                        n = el + (ev - v);
                        take = 1;
                     end
                  end
                  OV_RIGHT_PART: begin
                     if (v - ev == p - ep) begin
                        n = v + n - ev;
                        v = ev;
                        p = ep;
                        take = 1;
                     end
                  end
                  default: ;
               endcase
            end
            if (!take) begin
               i++;
            end else if (!has_slot) begin
               has_slot = 1;
               slot = i;
               i++;
            end else begin
               // The tail moves into this slot and is examined on the next pass.
               tab_virt[i] = tab_virt[count-1];
               tab_phys[i] = tab_phys[count-1];
               tab_len[i] = tab_len[count-1];
               count--;
            end
         end
         if (has_slot) begin
            tab_virt[slot] = v[47:0];
            tab_phys[slot] = p[47:0];
            tab_len[slot] = (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
            return 1;
         end
         if (covered) return 1;
         if (count >= SLOTS) return 0;
         tab_virt[count] = v[47:0];
         tab_phys[count] = p[47:0];
         tab_len[count] = n[31:0];
         count++;
         return 1;
      endfunction

      // Applies an accepted request and queues the response it owes.
      function void note_request(op_type op, logic [47:0] v, logic [47:0] p,
                                 logic [31:0] n, logic [6:0] sel);
         response_type r;
         longint unsigned d;
         r = '{ok: 0, virt: 0, phys: 0, secs: 0, idx: 0, cnt: 0};
         case (op)
            OP_ADD: r.ok = merge_extent(v, p, n);
            OP_REMOVE: begin
               if (n != 0) begin
                  for (int i = 0; i < count; i++) begin
                     if (tab_virt[i] == v && tab_len[i] == n) begin
                        tab_virt[i] = tab_virt[count-1];
                        tab_phys[i] = tab_phys[count-1];
                        tab_len[i] = tab_len[count-1];
                        count--;
                        r.ok = 1;
                        break;
                     end
                  end
               end
            end
            OP_LOOKUP: begin
               r.idx = 7'(count);
               for (int i = 0; i < count; i++) begin
                  if ({16'd0, v} >= tab_virt[i] &&
                      {16'd0, v} < {16'd0, tab_virt[i]} + tab_len[i]) begin
                     d = v - tab_virt[i];
                     r.ok = 1;
                     r.virt = tab_virt[i];
                     r.phys = 48'(tab_phys[i] + d);
                     r.secs = 32'(tab_len[i] - d);
                     r.idx = 7'(i + 1);
                     break;
                  end
               end
            end
            default: begin
               if (sel < count) begin
                  r.ok = 1;
                  r.virt = tab_virt[sel];
                  r.phys = tab_phys[sel];
                  r.secs = tab_len[sel];
               end
            end
         endcase
         r.cnt = 7'(count);
         owed.push_back(r);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
         errors++;
      endtask

      // Compares one accepted response with the oldest one owed.
      task check_response(logic ok, logic [143:0] data);
         response_type w;
         if (owed.size() == 0) begin
            report("unexpected response", data[63:0], 0);
            return;
         end
         w = owed.pop_front();
         if (ok !== w.ok) report("ok", ok, w.ok);
         if (data[47:0] !== w.virt) report("out_virtual", data[47:0], w.virt);
         if (data[95:48] !== w.phys) report("out_physical", data[95:48], w.phys);
         if (data[127:96] !== w.secs) report("out_sectors", data[127:96], w.secs);
         if (data[134:128] !== w.idx) report("out_index", data[134:128], w.idx);
         if (data[141:135] !== w.cnt) report("entry_count", data[141:135], w.cnt);
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;
   logic         rsp_tuser;

   extent_scoreboard board;
   int accepted;
   int burst_left;
   bit stimulus_done;

   extent_map_table #(.CAPACITY(SLOTS)) dut (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Offers one request from a falling edge until it is accepted, then handles idling.
   task send(op_type op, logic [47:0] v, logic [47:0] p, logic [31:0] n, logic [6:0] sel);
      req_tuser = op;
      req_tdata = {1'b0, sel, n, p, v};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(op, v, p, n, sel);
      accepted++;
      @(negedge clock);
      if (--burst_left <= 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
      end
   endtask

   function automatic logic [47:0] wide48();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[47:0];
   endfunction

   // One random request, mostly well formed against the current table contents.
   task random_request();
      int pick, k;
      logic [47:0] v, p;
      logic [31:0] n;
      pick = $urandom_range(0, 99);
      k = (board.count > 0) ? $urandom_range(0, board.count - 1) : 0;
      v = 48'($urandom_range(0, 3000));
      n = $urandom_range(1, 60);
      if (pick < 8) begin
         send(op_type'($urandom_range(0, 3)), wide48(), wide48(), $urandom,
              7'($urandom_range(0, 64)));
      end else if (pick < 48) begin
         case ($urandom_range(0, 3))
            0, 1: p = v;
            2: p = v + 48'(5000 * $urandom_range(1, 20));
            default: p = 48'($urandom_range(0, 3000));
         endcase
         send(OP_ADD, v, p, n, 7'($urandom_range(0, 64)));
      end else if (pick < 66) begin
         if (board.count > 0 && $urandom_range(0, 4) != 0)
            send(OP_REMOVE, board.tab_virt[k], wide48(), board.tab_len[k], 0);
         else
            send(OP_REMOVE, v, 0, n, 0);
      end else if (pick < 86) begin
         if (board.count > 0 && $urandom_range(0, 3) != 0)
            send(OP_LOOKUP,
                 board.tab_virt[k] + 48'($urandom_range(0, board.tab_len[k] - 1)),
                 0, 0, 0);
         else
            send(OP_LOOKUP, v, 0, 0, 0);
      end else begin
         send(OP_READ, 0, 0, 0, 7'($urandom_range(0, 64)));
      end
   endtask

   // Stimulus: directed cases, a fill to capacity, then random requests.
   initial begin
      board = new();
      accepted = 0;
      burst_left = 3;
      stimulus_done = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_ADD;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      send(OP_READ, 0, 0, 0, 0);
      send(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
      send(OP_ADD, 5, 5, 0, 0);
      send(OP_REMOVE, 5, 0, 0, 0);
      send(OP_ADD, 100, 100, 10, 0);
      send(OP_ADD, 120, 120, 10, 0);
      send(OP_ADD, 400, 900, 20, 0);
      // Merge across two entries: the second merged slot is refilled from the tail.
      send(OP_ADD, 105, 105, 20, 0);
      send(OP_ADD, 110, 110, 5, 0);
      send(OP_ADD, 420, 920, 8, 0);
      send(OP_ADD, 390, 890, 50, 0);
      send(OP_ADD, 0, 0, 32'hFFFF_FFFF, 0);
      send(OP_ADD, 48'hFFFF_FFFF, 48'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send(OP_ADD, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
      send(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
      send(OP_LOOKUP, 48'h1_0000_0000, 0, 0, 0);
      send(OP_READ, 0, 0, 0, 1);
      send(OP_READ, 0, 0, 0, 64);
      send(OP_REMOVE, 390, 0, 49, 0);
      send(OP_REMOVE, 390, 0, 50, 0);
      send(OP_READ, 0, 0, 0, 7'd127 >> 1);
      send(OP_LOOKUP, 395, 0, 0, 0);

      // Disjoint extents until the table is full and further adds fail.
      for (int i = 0; i < 70; i++)
         send(OP_ADD, 48'h8000_0000_0000 + 48'(i * 1000), 48'h4000_0000_0000 + 48'(i * 3000),
              10, 0);
      send(OP_READ, 0, 0, 0, 63);
      send(OP_READ, 0, 0, 0, 64);

      for (int i = 0; i < RANDOM_REQUESTS; i++)
         random_request();

      req_tvalid = 1'b0;
      stimulus_done = 1;
   end

   // Receiver: changing stall patterns, with one long hold-off to back the block up.
   initial begin
      int mode, held;
      rsp_tready = 1'b0;
      held = 0;
      mode = 0;
      @(negedge clock);
      forever begin
         if (!held && accepted >= 200) begin
            rsp_tready = 1'b0;
            repeat (900) @(negedge clock);
            held = 1;
         end
         if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = ($urandom_range(0, 3) != 0);
            2: rsp_tready = ($urandom_range(0, 3) == 0);
            default: rsp_tready = ~rsp_tready;
         endcase
         @(negedge clock);
      end
   end

   // Response checking at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tuser, rsp_tdata);
   end

   // Run end: drain the owed responses, keep the clock running a while longer, then judge.
   initial begin
      wait (stimulus_done);
      while (board.owed.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // Watchdog on the total cycle count.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

endmodule
